[design/assert_macros.svh]
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[design/wpsp_pkg.sv]
// shared types, codes and lookup functions of the wav pcm stream parser
`timescale 1ns / 1ps

package wpsp_pkg;

    // parser phases
    localparam logic [3:0] PH_RIFF      = 4'd0;
    localparam logic [3:0] PH_SIZE      = 4'd1;
    localparam logic [3:0] PH_WAVE      = 4'd2;
    localparam logic [3:0] PH_FMT_SEEK  = 4'd3;
    localparam logic [3:0] PH_FMT_PAD   = 4'd4;
    localparam logic [3:0] PH_FMT_BODY  = 4'd5;
    localparam logic [3:0] PH_DATA_SEEK = 4'd6;
    localparam logic [3:0] PH_DATA_SIZE = 4'd7;
    localparam logic [3:0] PH_SAMPLES   = 4'd8;
    localparam logic [3:0] PH_ERROR     = 4'd9;

    // status codes reported with every result
    localparam logic [3:0] ST_HEADER    = 4'd0;
    localparam logic [3:0] ST_SAMPLES   = 4'd1;
    localparam logic [3:0] ST_BAD_RIFF  = 4'd2;
    localparam logic [3:0] ST_BAD_WAVE  = 4'd3;
    localparam logic [3:0] ST_NO_FMT    = 4'd4;
    localparam logic [3:0] ST_FMT_SIZE  = 4'd5;
    localparam logic [3:0] ST_NOT_PCM   = 4'd6;
    localparam logic [3:0] ST_NOT_MONO  = 4'd7;
    localparam logic [3:0] ST_BAD_RATE  = 4'd8;
    localparam logic [3:0] ST_BAD_BITS  = 4'd9;
    localparam logic [3:0] ST_BAD_ALIGN = 4'd10;
    localparam logic [3:0] ST_NO_DATA   = 4'd11;

    // format check flag positions
    localparam logic [2:0] FLAG_SIZE  = 3'd0;
    localparam logic [2:0] FLAG_PCM   = 3'd1;
    localparam logic [2:0] FLAG_MONO  = 3'd2;
    localparam logic [2:0] FLAG_RATE  = 3'd3;
    localparam logic [2:0] FLAG_BITS  = 3'd4;
    localparam logic [2:0] FLAG_ALIGN = 3'd5;

    localparam logic [30:0] RATE_RESET = 31'd16000;
    localparam logic [4:0]  BODY_LEN   = 5'd20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } item_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic [3:0]         status;
        logic               beyond_declared;
    } result_t;

    typedef struct packed {
        logic [2:0] flag_bit;
        logic [7:0] exp_byte;
    } body_chk_t;

    function automatic logic [7:0] riff_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h52;
            2'd1:    c = 8'h49;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] wave_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h57;
            2'd1:    c = 8'h41;
            2'd2:    c = 8'h56;
            default: c = 8'h45;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] fmt_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h66;
            2'd1:    c = 8'h6D;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] data_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h64;
            2'd1:    c = 8'h61;
            2'd2:    c = 8'h74;
            default: c = 8'h61;
        endcase
        return c;
    endfunction

    // expected byte of the format body at pos and the flag it feeds
    function automatic body_chk_t body_expect(input logic [4:0] pos, input logic [30:0] rate);
        body_chk_t  chk;
        logic [31:0] rate32;
        logic [31:0] brate;
        rate32 = {1'b0, rate};
        brate  = {rate, 1'b0};
        if (pos < 5'd4)
        begin
            chk.flag_bit = FLAG_SIZE;
            chk.exp_byte = (pos == 5'd0) ? 8'd16 : 8'd0;
        end
        else if (pos < 5'd6)
        begin
            chk.flag_bit = FLAG_PCM;
            chk.exp_byte = (pos == 5'd4) ? 8'd1 : 8'd0;
        end
        else if (pos < 5'd8)
        begin
            chk.flag_bit = FLAG_MONO;
            chk.exp_byte = (pos == 5'd6) ? 8'd1 : 8'd0;
        end
        else if (pos < 5'd12)
        begin
            chk.flag_bit = FLAG_RATE;
            chk.exp_byte = rate32[{pos[1:0], 3'b000} +: 8];
        end
        else if (pos < 5'd16)
        begin
            chk.flag_bit = FLAG_ALIGN;
            chk.exp_byte = brate[{pos[1:0], 3'b000} +: 8];
        end
        else if (pos < 5'd18)
        begin
            chk.flag_bit = FLAG_ALIGN;
            chk.exp_byte = (pos == 5'd16) ? 8'd2 : 8'd0;
        end
        else
        begin
            chk.flag_bit = FLAG_BITS;
            chk.exp_byte = (pos == 5'd18) ? 8'd16 : 8'd0;
        end
        return chk;
    endfunction

endpackage

[design/wpsp_core.sv]
// parser state and the one-byte step that produces a result
`timescale 1ns / 1ps

module wpsp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  wpsp_pkg::item_t     item,
    input  logic [30:0]         rate,
    output wpsp_pkg::result_t   result
);

    logic [3:0]         phase_reg,  phase_next;
    logic [4:0]         bip_reg,    bip_next;
    logic [2:0]         mc_reg,     mc_next;
    logic [31:0]        size_reg,   size_next;
    logic signed [32:0] budget_reg, budget_next;
    logic [5:0]         flags_reg,  flags_next;
    logic [31:0]        left_reg,   left_next;
    logic [7:0]         low_reg,    low_next;
    logic               parity_reg, parity_next;
    logic [3:0]         err_reg,    err_next;

    always_comb
    begin
        logic [7:0]          b;
        logic                found;
        wpsp_pkg::body_chk_t chk;
        b     = item.data_byte;
        found = 1'b0;
        chk   = wpsp_pkg::body_expect(bip_reg, rate);

        phase_next  = phase_reg;
        bip_next    = bip_reg;
        mc_next     = mc_reg;
        size_next   = size_reg;
        budget_next = budget_reg;
        flags_next  = flags_reg;
        left_next   = left_reg;
        low_next    = low_reg;
        parity_next = parity_reg;
        err_next    = err_reg;
        if (item.first_byte)
        begin
            phase_next  = wpsp_pkg::PH_RIFF;
            bip_next    = 5'd0;
            mc_next     = 3'd0;
            size_next   = 32'd0;
            budget_next = 33'sd0;
            flags_next  = 6'd0;
            left_next   = 32'd0;
            low_next    = 8'd0;
            parity_next = 1'b0;
            err_next    = 4'd0;
            chk         = wpsp_pkg::body_expect(5'd0, rate);
        end

        result.sample          = 16'sd0;
        result.sample_valid    = 1'b0;
        result.beyond_declared = 1'b0;

        case (phase_next)
            wpsp_pkg::PH_RIFF:
            begin
                if (b != wpsp_pkg::riff_char(bip_next[1:0]))
                begin
                    phase_next = wpsp_pkg::PH_ERROR;
                    err_next   = wpsp_pkg::ST_BAD_RIFF;
                end
                else
                begin
                    bip_next = bip_next + 5'd1;
                    if (bip_next >= 5'd4)
                    begin
                        bip_next   = 5'd0;
                        phase_next = wpsp_pkg::PH_SIZE;
                    end
                end
            end
            wpsp_pkg::PH_SIZE:
            begin
                size_next = size_next | ({24'd0, b} << {bip_next[1:0], 3'b000});
                bip_next  = bip_next + 5'd1;
                if (bip_next >= 5'd4)
                begin
                    bip_next    = 5'd0;
                    budget_next = $signed({1'b0, size_next}) - 33'sd8;
                    phase_next  = wpsp_pkg::PH_WAVE;
                end
            end
            wpsp_pkg::PH_WAVE:
            begin
                if (b != wpsp_pkg::wave_char(bip_next[1:0]))
                begin
                    phase_next = wpsp_pkg::PH_ERROR;
                    err_next   = wpsp_pkg::ST_BAD_WAVE;
                end
                else
                begin
                    bip_next = bip_next + 5'd1;
                    if (bip_next >= 5'd4)
                    begin
                        bip_next   = 5'd0;
                        mc_next    = 3'd0;
                        phase_next = wpsp_pkg::PH_FMT_SEEK;
                    end
                end
            end
            wpsp_pkg::PH_FMT_SEEK:
            begin
                budget_next = budget_next - 33'sd1;
                if (mc_next < 3'd3 && b == wpsp_pkg::fmt_char(mc_next[1:0]))
                begin
                    mc_next = mc_next + 3'd1;
                    if (mc_next == 3'd3)
                    begin
                        mc_next = 3'd0;
                        found   = 1'b1;
                    end
                end
                else
                begin
                    // a breaking byte may itself start a new match
                    mc_next = (b == wpsp_pkg::fmt_char(2'd0)) ? 3'd1 : 3'd0;
                end
                if (found)
                    phase_next = wpsp_pkg::PH_FMT_PAD;
                else if (budget_next[32])
                begin
                    phase_next = wpsp_pkg::PH_ERROR;
                    err_next   = wpsp_pkg::ST_NO_FMT;
                end
            end
            wpsp_pkg::PH_FMT_PAD:
            begin
                budget_next = budget_next - 33'sd1;
                bip_next    = 5'd0;
                flags_next  = 6'd0;
                phase_next  = wpsp_pkg::PH_FMT_BODY;
            end
            wpsp_pkg::PH_FMT_BODY:
            begin
                if (b != chk.exp_byte)
                    flags_next[chk.flag_bit] = 1'b1;
                budget_next = budget_next - 33'sd1;
                bip_next    = bip_next + 5'd1;
                if (bip_next >= wpsp_pkg::BODY_LEN)
                begin
                    bip_next   = 5'd0;
                    mc_next    = 3'd0;
                    phase_next = wpsp_pkg::PH_ERROR;
                    // first failing test wins, in the order size, pcm, mono, rate, bits, align
                    if (flags_next[wpsp_pkg::FLAG_SIZE])
                        err_next = wpsp_pkg::ST_FMT_SIZE;
                    else if (flags_next[wpsp_pkg::FLAG_PCM])
                        err_next = wpsp_pkg::ST_NOT_PCM;
                    else if (flags_next[wpsp_pkg::FLAG_MONO])
                        err_next = wpsp_pkg::ST_NOT_MONO;
                    else if (flags_next[wpsp_pkg::FLAG_RATE])
                        err_next = wpsp_pkg::ST_BAD_RATE;
                    else if (flags_next[wpsp_pkg::FLAG_BITS])
                        err_next = wpsp_pkg::ST_BAD_BITS;
                    else if (flags_next[wpsp_pkg::FLAG_ALIGN])
                        err_next = wpsp_pkg::ST_BAD_ALIGN;
                    else
                        phase_next = wpsp_pkg::PH_DATA_SEEK;
                end
            end
            wpsp_pkg::PH_DATA_SEEK:
            begin
                budget_next = budget_next - 33'sd1;
                if (mc_next < 3'd4 && b == wpsp_pkg::data_char(mc_next[1:0]))
                begin
                    mc_next = mc_next + 3'd1;
                    if (mc_next == 3'd4)
                    begin
                        mc_next = 3'd0;
                        found   = 1'b1;
                    end
                end
                else
                begin
                    mc_next = (b == wpsp_pkg::data_char(2'd0)) ? 3'd1 : 3'd0;
                end
                if (found)
                begin
                    phase_next = wpsp_pkg::PH_DATA_SIZE;
                    bip_next   = 5'd0;
                    size_next  = 32'd0;
                end
                else if (budget_next[32])
                begin
                    phase_next = wpsp_pkg::PH_ERROR;
                    err_next   = wpsp_pkg::ST_NO_DATA;
                end
            end
            wpsp_pkg::PH_DATA_SIZE:
            begin
                size_next = size_next | ({24'd0, b} << {bip_next[1:0], 3'b000});
                bip_next  = bip_next + 5'd1;
                if (bip_next >= 5'd4)
                begin
                    bip_next    = 5'd0;
                    left_next   = size_next;
                    parity_next = 1'b0;
                    phase_next  = wpsp_pkg::PH_SAMPLES;
                end
            end
            wpsp_pkg::PH_SAMPLES:
            begin
                if (!parity_next)
                begin
                    low_next    = b;
                    parity_next = 1'b1;
                end
                else
                begin
                    result.sample       = $signed({b, low_next});
                    result.sample_valid = 1'b1;
                    if (left_next >= 32'd2)
                        left_next = left_next - 32'd2;
                    else
                        result.beyond_declared = 1'b1;
                    parity_next = 1'b0;
                end
            end
            wpsp_pkg::PH_ERROR:
            begin
                phase_next = wpsp_pkg::PH_ERROR;
            end
            default:
            begin
                phase_next = wpsp_pkg::PH_ERROR;
            end
        endcase

        if (phase_next == wpsp_pkg::PH_ERROR)
            result.status = err_next;
        else if (phase_next == wpsp_pkg::PH_SAMPLES)
            result.status = wpsp_pkg::ST_SAMPLES;
        else
            result.status = wpsp_pkg::ST_HEADER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wpsp_pkg::PH_RIFF;
            bip_reg    <= 5'd0;
            mc_reg     <= 3'd0;
            size_reg   <= 32'd0;
            budget_reg <= 33'sd0;
            flags_reg  <= 6'd0;
            left_reg   <= 32'd0;
            low_reg    <= 8'd0;
            parity_reg <= 1'b0;
            err_reg    <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            bip_reg    <= bip_next;
            mc_reg     <= mc_next;
            size_reg   <= size_next;
            budget_reg <= budget_next;
            flags_reg  <= flags_next;
            left_reg   <= left_next;
            low_reg    <= low_next;
            parity_reg <= parity_next;
            err_reg    <= err_next;
        end
    end

endmodule

[design/wpsp_out_buf.sv]
// two-entry result buffer between the parser step and the output stream
`timescale 1ns / 1ps

module wpsp_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wpsp_pkg::result_t   push_data,
    output logic                space,
    output logic                m_valid,
    input  logic                m_ready,
    output wpsp_pkg::result_t   m_data
);

    wpsp_pkg::result_t entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign m_valid = (count_reg != 2'd0);
    assign space   = (count_reg != 2'd2);
    assign pop     = m_valid && m_ready;
    assign m_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[design/wav_pcm_stream_parser_top.sv]
// top level of the wav pcm stream parser
`timescale 1ns / 1ps

// Parses a RIFF/WAVE file presented one byte per transaction on the s_ side and
// returns one result per byte on the m_ side: a signed 16-bit mono PCM sample
// when the byte completes one, and a status code for the header, the sample
// section or the error that stopped parsing (sticky until a byte marked as the
// first byte of a new file). The block takes one byte per cycle sustained while
// m_tready is high; a byte goes through the input register, then the parser
// step, which is combinational, and its result is written into the two-entry
// output buffer that drives the m_ side. While m_tready stays low the block
// takes three bytes (two buffered results and one byte waiting in the input
// register) before s_tready drops. The required sample rate is written on the
// cfg channel, which is always ready; the user must write it only while no byte
// is in flight, which the block does not enforce itself. It resets to 16000.

module wav_pcm_stream_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,     // required_sample_rate
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // data_byte
    input  logic        s_tuser,      // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // sample
    output logic [5:0]  m_tuser       // sample_valid, status[3:0], beyond_declared
);

    logic [30:0]       rate_reg;
    logic              in_valid_reg;
    wpsp_pkg::item_t   in_item_reg;
    logic              fire;
    logic              space;
    wpsp_pkg::result_t step_result;
    wpsp_pkg::result_t out_result;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && space;
    assign s_tready  = !in_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= wpsp_pkg::RATE_RESET;
        else if (cfg_valid && cfg_ready)
            rate_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.data_byte  <= s_tdata;
            in_item_reg.first_byte <= s_tuser;
        end
    end

    wpsp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .rate   (rate_reg),
        .result (step_result)
    );

    wpsp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (step_result),
        .space     (space),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_result)
    );

    assign m_tdata = out_result.sample;
    assign m_tuser = {out_result.beyond_declared, out_result.status, out_result.sample_valid};

endmodule

[design/wpsp_checker.sv]
// port-level checks of the wav pcm stream parser and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wpsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [5:0]  m_tuser
);

    // a stalled result keeps its payload
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // no sample means zero sample and no overrun mark
    `ASSERT_CLK(a_idle_zero, m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0 && !m_tuser[5], "payload without sample")

    // overrun mark only on an emitted sample
    `ASSERT_NEVER(a_beyond_alone, m_tvalid && m_tuser[5] && !m_tuser[0], "overrun mark without sample")

    // samples are only emitted in the sample section
    `ASSERT_CLK(a_sample_status, m_tvalid && m_tuser[0] |-> m_tuser[4:1] == wpsp_pkg::ST_SAMPLES, "sample with wrong status")

endmodule

bind wav_pcm_stream_parser_top wpsp_checker u_wpsp_checker (.*);
